// File: rtl/ntw_pkg.sv
`timescale 1ns / 1ps

package ntw_pkg;

    // defaults for the top-level parameters
    localparam int unsigned DEF_MAX_DEPTH         = 8;
    localparam int unsigned DEF_MAX_MESSAGE_BYTES = 65535;

    // queue depths (powers of two, pointers wrap naturally)
    localparam int unsigned IN_DEPTH  = 2;
    localparam int unsigned OUT_DEPTH = 4;

    // commands
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_DATA  = 1'b1;

    // result kinds
    localparam logic [2:0] K_HEADER    = 3'd0;
    localparam logic [2:0] K_PAYLOAD   = 3'd1;
    localparam logic [2:0] K_GROUP_END = 3'd2;
    localparam logic [2:0] K_MSG_END   = 3'd3;
    localparam logic [2:0] K_ERROR     = 3'd4;

    // error codes
    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_BOUNDS = 2'd1;
    localparam logic [1:0] ERR_SHORT  = 2'd2;
    localparam logic [1:0] ERR_DEEP   = 2'd3;

    // walker status
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;
    localparam logic [1:0] ST_ERR  = 2'd3;

    // input beat plus pre-decoded header fields
    typedef struct packed {
        logic        cmd;
        logic [15:0] msg_len;
        logic [31:0] word;
        logic [12:0] hdr_len;
        logic [13:0] aligned;
        logic        len_short;
        logic        grouping;
        logic [10:0] body_words;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_front_out;

    typedef struct packed {
        logic [2:0]  kind;
        logic [5:0]  ns;
        logic [9:0]  code;
        logic [1:0]  dtype;
        logic        list;
        logic [12:0] len;
        logic [3:0]  level;
        logic [31:0] word;
        logic [1:0]  err;
        logic        last;
    } t_result;

endpackage

// File: rtl/ntw_front.sv
`timescale 1ns / 1ps

module ntw_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [1:0]          i_cfg_wr_data,
    input  logic                push,
    output logic                full,
    input  logic                i_command,
    input  logic [15:0]         i_message_length,
    input  logic [31:0]         i_data_word,
    output ntw_pkg::t_front_out o_fr,
    input  logic                i_take
);
    import ntw_pkg::*;

    localparam int unsigned IW = $clog2(IN_DEPTH);
    localparam int unsigned CW = IW + 1;

    logic [1:0]    r_obj_type;
    t_item         r_q [IN_DEPTH];
    logic [IW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;

    logic [12:0] w_len;
    logic [13:0] w_aligned;
    logic        w_wr, w_rd;
    t_item       w_item;

    // header decode
    always_comb begin
        w_len     = i_data_word[28:16];
        w_aligned = ({1'b0, w_len} + 14'd3) & ~14'd3;
        w_item.cmd        = i_command;
        w_item.msg_len    = i_message_length;
        w_item.word       = i_data_word;
        w_item.hdr_len    = w_len;
        w_item.aligned    = w_aligned;
        w_item.len_short  = (w_len < 13'd4);
        w_item.grouping   = (i_data_word[29] || (i_data_word[31:30] == r_obj_type))
                            && (w_len > 13'd4);
        w_item.body_words = 11'(w_aligned[13:2] - 12'd1);
    end

    assign full      = (r_cnt == CW'(IN_DEPTH));
    assign w_wr      = push && !full;
    assign w_rd      = i_take && (r_cnt != '0);
    assign o_fr.valid = (r_cnt != '0);
    assign o_fr.item  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_obj_type <= 2'd0;
            r_wp       <= '0;
            r_rp       <= '0;
            r_cnt      <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_obj_type <= i_cfg_wr_data;
            end
            if (w_wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_rd) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + CW'(w_wr) - CW'(w_rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_q[r_wp] <= w_item;
        end
    end

endmodule

// File: rtl/ntw_walker.sv
`timescale 1ns / 1ps

module ntw_walker #(
    parameter int unsigned MAX_DEPTH         = ntw_pkg::DEF_MAX_DEPTH,
    parameter int unsigned MAX_MESSAGE_BYTES = ntw_pkg::DEF_MAX_MESSAGE_BYTES
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ntw_pkg::t_front_out i_fr,
    output logic                o_take,
    input  logic                i_out_full,
    output logic                o_push,
    output ntw_pkg::t_result    o_res
);
    import ntw_pkg::*;

    localparam int unsigned DW = $clog2(MAX_DEPTH + 1);
    localparam int unsigned SW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam logic [16:0] MAX_MSG = 17'(MAX_MESSAGE_BYTES);

    localparam logic [1:0] S_ITEM  = 2'd0;
    localparam logic [1:0] S_CLOSE = 2'd1;
    localparam logic [1:0] S_LOAD  = 2'd2;
    localparam logic [1:0] S_FLUSH = 2'd3;

    function automatic t_result mk_res(input logic [2:0] kind, input logic [5:0] ns,
                                       input logic [9:0] code, input logic [1:0] dtype,
                                       input logic list, input logic [12:0] len,
                                       input logic [3:0] level, input logic [31:0] word,
                                       input logic [1:0] err);
        t_result r;
        r.kind  = kind;
        r.ns    = ns;
        r.code  = code;
        r.dtype = dtype;
        r.list  = list;
        r.len   = len;
        r.level = level;
        r.word  = word;
        r.err   = err;
        r.last  = 1'b0;
        return r;
    endfunction

    logic [1:0]    r_state, n_state;
    logic [16:0]   r_pos, n_pos;
    logic [15:0]   r_limit, n_limit;
    logic [10:0]   r_left, n_left;
    logic [DW-1:0] r_depth, n_depth;
    logic [1:0]    r_status, n_status;
    logic [16:0]   r_top_end, n_top_end;
    logic          r_top_list, n_top_list;
    logic [12:0]   r_top_len, n_top_len;
    t_result       r_pend, n_pend;
    logic          r_pend_v, n_pend_v;

    // stack entries below the cached top
    logic [16:0] m_end  [MAX_DEPTH];
    logic        m_list [MAX_DEPTH];
    logic [12:0] m_len  [MAX_DEPTH];
    logic [16:0] r_rd_end;
    logic        r_rd_list;
    logic [12:0] r_rd_len;

    logic          w_mem_wr, w_mem_rd;
    logic [DW-1:0] w_dm1, w_dm2;
    logic          w_step;
    t_item         w_it;
    logic [3:0]    w_level;
    logic [16:0]   w_bound;
    logic [17:0]   w_end_sum;
    t_result       w_res;
    logic          w_have;

    assign w_dm1   = r_depth - DW'(1);
    assign w_dm2   = r_depth - DW'(2);
    assign w_step  = !i_out_full;
    assign w_it    = i_fr.item;
    assign w_level = 4'(r_depth);
    assign w_bound = (r_depth != '0) ? r_top_end : {1'b0, r_limit};
    assign w_end_sum = {1'b0, r_pos} + 18'(w_it.hdr_len);

    always_comb begin
        n_state    = r_state;
        n_pos      = r_pos;
        n_limit    = r_limit;
        n_left     = r_left;
        n_depth    = r_depth;
        n_status   = r_status;
        n_top_end  = r_top_end;
        n_top_list = r_top_list;
        n_top_len  = r_top_len;
        n_pend     = r_pend;
        n_pend_v   = r_pend_v;
        o_take     = 1'b0;
        o_push     = 1'b0;
        o_res      = r_pend;
        w_mem_wr   = 1'b0;
        w_mem_rd   = 1'b0;
        w_res      = mk_res(K_HEADER, '0, '0, '0, 1'b0, '0, '0, '0, ERR_NONE);
        w_have     = 1'b0;

        case (r_state)
            S_ITEM: begin
                if (i_fr.valid && w_step) begin
                    o_take = 1'b1;
                    if (w_it.cmd == CMD_START) begin
                        n_pos    = '0;
                        n_limit  = w_it.msg_len;
                        n_left   = '0;
                        n_depth  = '0;
                        n_status = ST_RUN;
                        if ({1'b0, w_it.msg_len} > MAX_MSG) begin
                            o_push     = 1'b1;
                            o_res      = mk_res(K_ERROR, '0, '0, '0, 1'b0, '0, '0, '0,
                                                ERR_BOUNDS);
                            o_res.last = 1'b1;
                            n_status   = ST_ERR;
                        end else begin
                            n_state = S_CLOSE;
                        end
                    end else if (r_status == ST_RUN) begin
                        w_have = 1'b1;
                        if (r_left != '0) begin
                            w_res  = mk_res(K_PAYLOAD, '0, '0, '0, 1'b0, '0, w_level,
                                            w_it.word, ERR_NONE);
                            n_left = r_left - 11'd1;
                            n_pos  = r_pos + 17'd4;
                            if (r_left == 11'd1) begin
                                w_have   = 1'b0;
                                n_pend   = w_res;
                                n_pend_v = 1'b1;
                                n_state  = S_CLOSE;
                            end
                        end else if (w_it.len_short) begin
                            w_res    = mk_res(K_ERROR, '0, '0, '0, 1'b0, '0, w_level, '0,
                                              ERR_SHORT);
                            n_status = ST_ERR;
                        end else if (w_end_sum > {1'b0, w_bound}) begin
                            w_res    = mk_res(K_ERROR, '0, '0, '0, 1'b0, '0, w_level, '0,
                                              ERR_BOUNDS);
                            n_status = ST_ERR;
                        end else if (w_it.grouping && (r_depth >= DW'(MAX_DEPTH))) begin
                            w_res    = mk_res(K_ERROR, '0, '0, '0, 1'b0, '0, w_level, '0,
                                              ERR_DEEP);
                            n_status = ST_ERR;
                        end else begin
                            w_res = mk_res(K_HEADER, w_it.word[15:10], w_it.word[9:0],
                                           w_it.word[31:30], w_it.word[29], w_it.hdr_len,
                                           w_level, '0, ERR_NONE);
                            n_pos = r_pos + 17'd4;
                            if (w_it.grouping) begin
                                // spill the old top, cache the new group
                                w_mem_wr   = (r_depth != '0);
                                n_top_end  = r_pos + 17'(w_it.aligned);
                                n_top_list = w_it.word[29];
                                n_top_len  = w_it.hdr_len;
                                n_depth    = r_depth + DW'(1);
                            end else begin
                                n_left = w_it.body_words;
                                if (w_it.body_words == '0) begin
                                    w_have   = 1'b0;
                                    n_pend   = w_res;
                                    n_pend_v = 1'b1;
                                    n_state  = S_CLOSE;
                                end
                            end
                        end
                        if (w_have) begin
                            o_push     = 1'b1;
                            o_res      = w_res;
                            o_res.last = 1'b1;
                        end
                    end
                end
            end

            S_CLOSE: begin
                if (w_step) begin
                    if ((r_depth != '0) && (r_pos >= r_top_end)) begin
                        w_res   = mk_res(K_GROUP_END, '0, '0, '0, r_top_list, r_top_len,
                                         4'(w_dm1), '0, ERR_NONE);
                        w_have  = 1'b1;
                        n_depth = w_dm1;
                        if (r_depth > DW'(1)) begin
                            w_mem_rd = 1'b1;
                            n_state  = S_LOAD;
                        end
                    end else if (r_depth == '0) begin
                        if (r_pos == {1'b0, r_limit}) begin
                            w_res    = mk_res(K_MSG_END, '0, '0, '0, 1'b0, '0, '0, '0,
                                              ERR_NONE);
                            w_have   = 1'b1;
                            n_status = ST_DONE;
                        end else if (({1'b0, r_pos} + 18'd4) > {2'b0, r_limit}) begin
                            w_res    = mk_res(K_ERROR, '0, '0, '0, 1'b0, '0, '0, '0,
                                              ERR_BOUNDS);
                            w_have   = 1'b1;
                            n_status = ST_ERR;
                        end
                        n_state = w_have ? S_FLUSH : S_ITEM;
                    end else begin
                        n_state = S_ITEM;
                    end

                    if (w_have) begin
                        // older staged result is not the last one
                        o_push     = r_pend_v;
                        o_res      = r_pend;
                        o_res.last = 1'b0;
                        n_pend     = w_res;
                        n_pend_v   = 1'b1;
                    end else begin
                        o_push     = r_pend_v;
                        o_res      = r_pend;
                        o_res.last = 1'b1;
                        n_pend_v   = 1'b0;
                    end
                end
            end

            S_LOAD: begin
                n_top_end  = r_rd_end;
                n_top_list = r_rd_list;
                n_top_len  = r_rd_len;
                n_state    = S_CLOSE;
            end

            S_FLUSH: begin
                if (w_step) begin
                    o_push     = 1'b1;
                    o_res      = r_pend;
                    o_res.last = 1'b1;
                    n_pend_v   = 1'b0;
                    n_state    = S_ITEM;
                end
            end

            default: begin
                n_state = S_ITEM;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_ITEM;
            r_pos    <= '0;
            r_limit  <= '0;
            r_left   <= '0;
            r_depth  <= '0;
            r_status <= ST_IDLE;
            r_pend_v <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pos    <= n_pos;
            r_limit  <= n_limit;
            r_left   <= n_left;
            r_depth  <= n_depth;
            r_status <= n_status;
            r_pend_v <= n_pend_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top_end  <= n_top_end;
        r_top_list <= n_top_list;
        r_top_len  <= n_top_len;
        r_pend     <= n_pend;
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_wr) begin
            m_end[w_dm1[SW-1:0]]  <= r_top_end;
            m_list[w_dm1[SW-1:0]] <= r_top_list;
            m_len[w_dm1[SW-1:0]]  <= r_top_len;
        end
        if (w_mem_rd) begin
            r_rd_end  <= m_end[w_dm2[SW-1:0]];
            r_rd_list <= m_list[w_dm2[SW-1:0]];
            r_rd_len  <= m_len[w_dm2[SW-1:0]];
        end
    end

endmodule

// File: rtl/ntw_rq.sv
`timescale 1ns / 1ps

module ntw_rq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  ntw_pkg::t_result i_res,
    output logic             o_full,
    output logic             o_empty,
    input  logic             i_pop,
    output ntw_pkg::t_result o_head
);
    import ntw_pkg::*;

    localparam int unsigned IW = $clog2(OUT_DEPTH);
    localparam int unsigned CW = IW + 1;

    t_result       r_q [OUT_DEPTH];
    logic [IW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;
    logic          w_wr, w_rd;

    assign o_full  = (r_cnt == CW'(OUT_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign o_head  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_rd) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + CW'(w_wr) - CW'(w_rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_q[r_wp] <= i_res;
        end
    end

endmodule

// File: rtl/nested_tlv_stream_walker.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake         Payload
// input     in         push / full       i_command, i_message_length, i_data_word
// result    out        empty / pop       o_result_kind .. o_last_result (10 fields)
// config    in         i_cfg_wr_en       i_cfg_wr_data (object type code)
//
// A beat that ends an entry has its result held for the end check, then unwinds its group
// ends one by one; each end but the outermost reloads the cached stack top from memory.
// Reset (i_rst_n low at a clock edge) empties both queues and puts the walker idle.
// full rises when the 2-deep input queue holds two beats; the walker waits on a full result queue.

module nested_tlv_stream_walker #(
    parameter int unsigned MAX_DEPTH         = ntw_pkg::DEF_MAX_DEPTH,
    parameter int unsigned MAX_MESSAGE_BYTES = ntw_pkg::DEF_MAX_MESSAGE_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_wr_data,
    // input beats
    input  logic        push,
    output logic        full,
    input  logic        i_command,
    input  logic [15:0] i_message_length,
    input  logic [31:0] i_data_word,
    // result beats
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_result_kind,
    output logic [5:0]  o_namespace_id,
    output logic [9:0]  o_entry_code,
    output logic [1:0]  o_data_type,
    output logic        o_is_list,
    output logic [12:0] o_entry_length,
    output logic [3:0]  o_nesting_level,
    output logic [31:0] o_payload_word,
    output logic [1:0]  o_error_code,
    output logic        o_last_result
);
    import ntw_pkg::*;

    t_front_out w_fr;      // front queue head
    logic       w_take;    // walker consumes the head
    logic       w_rq_full;
    logic       w_rq_push;
    t_result    w_res;     // result from walker
    t_result    w_head;    // oldest waiting result

    // front: config register, header decode, input queue
    ntw_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .push             (push),
        .full             (full),
        .i_command        (i_command),
        .i_message_length (i_message_length),
        .i_data_word      (i_data_word),
        .o_fr             (w_fr),
        .i_take           (w_take)
    );

    // back: position tracking, group stack, result sequencing
    ntw_walker #(
        .MAX_DEPTH         (MAX_DEPTH),
        .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
    ) u_walker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fr       (w_fr),
        .o_take     (w_take),
        .i_out_full (w_rq_full),
        .o_push     (w_rq_push),
        .o_res      (w_res)
    );

    // result queue decouples walker from the consumer
    ntw_rq u_rq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_rq_push),
        .i_res   (w_res),
        .o_full  (w_rq_full),
        .o_empty (empty),
        .i_pop   (pop),
        .o_head  (w_head)
    );

    assign o_result_kind   = w_head.kind;
    assign o_namespace_id  = w_head.ns;
    assign o_entry_code    = w_head.code;
    assign o_data_type     = w_head.dtype;
    assign o_is_list       = w_head.list;
    assign o_entry_length  = w_head.len;
    assign o_nesting_level = w_head.level;
    assign o_payload_word  = w_head.word;
    assign o_error_code    = w_head.err;
    assign o_last_result   = w_head.last;

    // an error always ends the beat's results and carries a nonzero code
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_result_kind == K_ERROR)) |-> (o_error_code != ERR_NONE && o_last_result))
        else $error("error result without code or not last");

    // message end is last and at the outer level
    a_msg_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_result_kind == K_MSG_END)) |-> (o_last_result && o_nesting_level == 4'd0))
        else $error("message end not last or not at outer level");

    // header fields only in header results
    a_hdr_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_result_kind != K_HEADER))
            |-> (o_namespace_id == 6'd0 && o_entry_code == 10'd0 && o_data_type == 2'd0))
        else $error("header fields set outside a header result");

    // payload word only in payload results
    a_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_result_kind != K_PAYLOAD)) |-> (o_payload_word == 32'd0))
        else $error("payload word set outside a payload result");

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps

// Self-checking bench for the nested TLV stream walker.
// A driver process pushes beats from a backlog, and a shadow walker predicts
// every result beat the moment its input beat is accepted. A monitor process
// pops results on its own stall pattern and compares them field by field.

module tb_top;
    import ntw_pkg::*;

    localparam int unsigned WALK_DEPTH      = DEF_MAX_DEPTH;
    localparam int unsigned WALK_MAX_MSG    = DEF_MAX_MESSAGE_BYTES;
    localparam int unsigned SETTLE_CYCLES   = 48;
    localparam int unsigned RX_HOLD_CYCLES  = 300;     // long receiver hold-off
    localparam int unsigned CYCLE_LIMIT     = 400000;
    localparam int unsigned BEATS_PER_PHASE = 40;

    typedef struct {
        logic        cmd;
        logic [15:0] msg_len;
        logic [31:0] word;
    } t_beat;

    // ------------------------------------------------------------------
    // DUT signals, all inputs known from time zero
    // ------------------------------------------------------------------
    logic        i_clk            = 1'b0;
    logic        i_rst_n          = 1'b0;
    logic        i_cfg_wr_en      = 1'b0;
    logic [1:0]  i_cfg_wr_data    = 2'd0;
    logic        push             = 1'b0;
    logic        full;
    logic        i_command        = CMD_DATA;
    logic [15:0] i_message_length = 16'd0;
    logic [31:0] i_data_word      = 32'd0;
    logic        empty;
    logic        pop              = 1'b0;
    logic [2:0]  o_result_kind;
    logic [5:0]  o_namespace_id;
    logic [9:0]  o_entry_code;
    logic [1:0]  o_data_type;
    logic        o_is_list;
    logic [12:0] o_entry_length;
    logic [3:0]  o_nesting_level;
    logic [31:0] o_payload_word;
    logic [1:0]  o_error_code;
    logic        o_last_result;

    nested_tlv_stream_walker u_top (.*);

    always #10 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Shadow walker: state kept at the block's widths. Positions and group
    // ends carry one extra bit so an aligned end of 65536 fits.
    // ------------------------------------------------------------------
    logic [1:0]  obj_type_cfg = 2'd0;
    logic [16:0] walk_pos     = '0;
    logic [15:0] walk_limit   = '0;
    logic [10:0] body_left    = '0;
    logic [3:0]  walk_depth   = '0;
    logic [1:0]  walk_state   = ST_IDLE;
    logic [16:0] grp_end  [WALK_DEPTH];
    logic        grp_list [WALK_DEPTH];
    logic [12:0] grp_len  [WALK_DEPTH];

    t_result due_results [$];     // predicted result beats, oldest first
    t_beat   beat_backlog [$];    // beats waiting for the driver
    t_beat   draft_beats [$];     // message under construction

    int unsigned hold_token     = 0;
    int unsigned beats_taken    = 0;
    int unsigned results_seen   = 0;
    int unsigned group_ends     = 0;
    int unsigned msg_ends       = 0;
    int unsigned errors_seen    = 0;
    int unsigned cfg_writes     = 0;
    int unsigned mismatch_count = 0;

    function automatic void expect_result(input logic [2:0] kind, input logic [5:0] ns,
            input logic [9:0] code, input logic [1:0] dtype, input logic list,
            input logic [12:0] len, input logic [3:0] level, input logic [31:0] word,
            input logic [1:0] err);
        t_result r;
        r.kind  = kind;
        r.ns    = ns;
        r.code  = code;
        r.dtype = dtype;
        r.list  = list;
        r.len   = len;
        r.level = level;
        r.word  = word;
        r.err   = err;
        r.last  = 1'b0;
        due_results.push_back(r);
    endfunction

    // errors latch until the next start
    function automatic void walk_fail(input logic [1:0] err);
        expect_result(K_ERROR, '0, '0, '0, 1'b0, '0, walk_depth, '0, err);
        walk_state = ST_ERR;
    endfunction

    // outermost level: message complete, or too few bytes left for a header
    function automatic void check_outer();
        if (walk_pos == walk_limit) begin
            expect_result(K_MSG_END, '0, '0, '0, 1'b0, '0, '0, '0, ERR_NONE);
            walk_state = ST_DONE;
        end else if (walk_pos + 4 > walk_limit) begin
            walk_fail(ERR_BOUNDS);
        end
    endfunction

    // an entry just ended: unwind every group ending here
    function automatic void close_groups();
        while (walk_depth > 0 && walk_pos >= grp_end[walk_depth - 1]) begin
            walk_depth = walk_depth - 4'd1;
            expect_result(K_GROUP_END, '0, '0, '0, grp_list[walk_depth],
                          grp_len[walk_depth], walk_depth, '0, ERR_NONE);
        end
        if (walk_depth == 0)
            check_outer();
    endfunction

    function automatic void walk_word(input logic cmd, input logic [15:0] mlen,
                                      input logic [31:0] w);
        int unsigned n0;
        int unsigned bound;
        int unsigned aligned;
        logic [1:0]  ty;
        logic        lst;
        logic [12:0] hlen;
        logic        grp;
        n0 = due_results.size();
        if (cmd == CMD_START) begin
            walk_pos   = '0;
            walk_limit = mlen;
            body_left  = '0;
            walk_depth = '0;
            walk_state = ST_RUN;
            if (int'(mlen) > WALK_MAX_MSG)
                walk_fail(ERR_BOUNDS);
            else
                check_outer();
        end else if (walk_state == ST_RUN) begin
            if (body_left > 0) begin
                expect_result(K_PAYLOAD, '0, '0, '0, 1'b0, '0, walk_depth, w, ERR_NONE);
                body_left = body_left - 11'd1;
                walk_pos  = walk_pos + 17'd4;
                if (body_left == 0)
                    close_groups();
            end else begin
                ty      = w[31:30];
                lst     = w[29];
                hlen    = w[28:16];
                bound   = 32'((walk_depth > 0) ? grp_end[walk_depth - 1]
                                               : {1'b0, walk_limit});
                aligned = (hlen + 3) & 32'hFFFF_FFFC;
                grp     = (lst || ty == obj_type_cfg) && hlen > 4;
                if (hlen < 4) begin
                    walk_fail(ERR_SHORT);
                end else if (walk_pos + hlen > bound) begin
                    walk_fail(ERR_BOUNDS);
                end else if (grp && walk_depth >= WALK_DEPTH) begin
                    walk_fail(ERR_DEEP);
                end else begin
                    expect_result(K_HEADER, w[15:10], w[9:0], ty, lst, hlen, walk_depth,
                                  '0, ERR_NONE);
                    if (grp) begin
                        grp_end[walk_depth]  = 17'(walk_pos + aligned);
                        grp_list[walk_depth] = lst;
                        grp_len[walk_depth]  = hlen;
                        walk_depth = walk_depth + 4'd1;
                        walk_pos   = walk_pos + 17'd4;
                    end else begin
                        walk_pos  = walk_pos + 17'd4;
                        body_left = 11'((aligned - 4) >> 2);
                        if (body_left == 0)
                            close_groups();
                    end
                end
            end
        end
        // last_result marks the final beat caused by this input
        if (due_results.size() > n0)
            due_results[due_results.size() - 1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------
    function automatic logic [31:0] tlv_header(input logic [1:0] ty, input logic lst,
            input logic [12:0] len, input logic [5:0] ns, input logic [9:0] code);
        return {ty, lst, len, ns, code};
    endfunction

    function automatic void stage_beat(input logic cmd, input logic [15:0] mlen,
                                       input logic [31:0] w);
        t_beat b;
        b.cmd     = cmd;
        b.msg_len = mlen;
        b.word    = w;
        draft_beats.push_back(b);
    endfunction

    function automatic void commit_draft();
        foreach (draft_beats[i])
            beat_backlog.push_back(draft_beats[i]);
        draft_beats.delete();
    endfunction

    // Well-formed message with random shape: room[] tracks bytes left in each
    // open level; groups nest until the room runs out. Entering a group at full
    // depth is allowed once in a while, so the too-deep error shows up randomly.
    function automatic void build_message(input logic [1:0] obj);
        int unsigned room [WALK_DEPTH + 2];
        int          lvl;
        int unsigned fill;
        int unsigned mlen;
        int unsigned alen;
        int unsigned hlen;
        int unsigned cap;
        logic [1:0]  ty;
        logic        lst;
        fill = 4 * $urandom_range(1, 30);
        case ($urandom_range(0, 7))
            0: mlen = fill + $urandom_range(1, 3);       // short tail after last entry
            1: mlen = fill + 4 * $urandom_range(1, 4);   // message left open
            default: mlen = fill;
        endcase
        stage_beat(CMD_START, mlen[15:0], $urandom);
        room[0] = fill;
        lvl     = 0;
        while (lvl >= 0) begin
            if (room[lvl] == 0) begin
                lvl--;
            end else begin
                cap  = (room[lvl] / 4 > 12) ? 12 : room[lvl] / 4;
                alen = 4 * $urandom_range(1, cap);
                hlen = (alen > 4 && $urandom_range(0, 3) == 0) ? alen - $urandom_range(1, 3)
                                                               : alen;
                room[lvl] -= alen;
                if (alen > 4 && lvl <= WALK_DEPTH && $urandom_range(0, 2) != 0) begin
                    lst = 1'($urandom_range(0, 1));
                    ty  = lst ? 2'($urandom_range(0, 3)) : obj;
                    stage_beat(CMD_DATA, 16'($urandom),
                               tlv_header(ty, lst, 13'(hlen), 6'($urandom), 10'($urandom)));
                    lvl++;
                    room[lvl] = alen - 4;
                end else begin
                    if (alen == 4) begin
                        lst = 1'($urandom_range(0, 1));
                        ty  = 2'($urandom_range(0, 3));
                    end else begin
                        lst = 1'b0;
                        ty  = 2'($urandom_range(0, 3));
                        if (ty == obj)
                            ty = ty + 2'd1;
                    end
                    stage_beat(CMD_DATA, 16'($urandom),
                               tlv_header(ty, lst, 13'(hlen), 6'($urandom), 10'($urandom)));
                    for (int unsigned k = 4; k < alen; k += 4)
                        stage_beat(CMD_DATA, 16'($urandom), $urandom);
                end
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Driver: bursts of random length, random gaps; predicts on accept
    // ------------------------------------------------------------------
    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;
    t_beat       next_beat;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                walk_word(i_command, i_message_length, i_data_word);
                beats_taken++;
            end
            if (push && full) begin
                // beat stays on the port until taken
            end else if (gap_left > 0) begin
                gap_left--;
                push <= 1'b0;
            end else if (beat_backlog.size() > 0) begin
                next_beat = beat_backlog.pop_front();
                i_command        <= next_beat.cmd;
                i_message_length <= next_beat.msg_len;
                i_data_word      <= next_beat.word;
                push             <= 1'b1;
                if (burst_left == 0)
                    burst_left = $urandom_range(1, 16);
                burst_left--;
                if (burst_left == 0)
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
                push <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compares each popped beat with the oldest prediction
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    task automatic check_result();
        t_result got;
        t_result want;
        string   bad;
        got.kind  = o_result_kind;
        got.ns    = o_namespace_id;
        got.code  = o_entry_code;
        got.dtype = o_data_type;
        got.list  = o_is_list;
        got.len   = o_entry_length;
        got.level = o_nesting_level;
        got.word  = o_payload_word;
        got.err   = o_error_code;
        got.last  = o_last_result;
        results_seen++;
        if (due_results.size() == 0) begin
            report_mismatch($sformatf("result beat %0d with nothing predicted, kind %0d",
                                      results_seen, got.kind));
        end else begin
            want = due_results.pop_front();
            bad  = "";
            if (got.kind  !== want.kind)  bad = {bad, " kind"};
            if (got.ns    !== want.ns)    bad = {bad, " namespace"};
            if (got.code  !== want.code)  bad = {bad, " code"};
            if (got.dtype !== want.dtype) bad = {bad, " type"};
            if (got.list  !== want.list)  bad = {bad, " list"};
            if (got.len   !== want.len)   bad = {bad, " length"};
            if (got.level !== want.level) bad = {bad, " level"};
            if (got.word  !== want.word)  bad = {bad, " payload"};
            if (got.err   !== want.err)   bad = {bad, " error"};
            if (got.last  !== want.last)  bad = {bad, " last"};
            if (bad != "")
                report_mismatch($sformatf("result beat %0d:%s; got %h want %h",
                                          results_seen, bad, got, want));
            if (want.kind == K_GROUP_END) group_ends++;
            if (want.kind == K_MSG_END)   msg_ends++;
            if (want.kind == K_ERROR)     errors_seen++;
        end
    endtask

    // receiver stall pattern: a mode re-picked at random intervals, plus a
    // long hold-off whenever the stimulus bumps hold_token
    int unsigned rx_hold_left = 0;
    int unsigned rx_mode_left = 0;
    int unsigned rx_mode      = 0;
    int unsigned hold_seen    = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty)
                check_result();
            if (hold_seen != hold_token) begin
                hold_seen    = hold_token;
                rx_hold_left = RX_HOLD_CYCLES;
            end
            if (rx_mode_left == 0) begin
                rx_mode      = $urandom_range(0, 3);
                rx_mode_left = $urandom_range(16, 80);
            end
            rx_mode_left--;
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                pop <= 1'b0;
            end else begin
                case (rx_mode)
                    0: pop <= 1'b1;                           // no stalls
                    1: pop <= ($urandom_range(0, 1) == 0);
                    2: pop <= ($urandom_range(0, 3) == 0);    // heavy stalls
                    default: pop <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------
    int unsigned cycle_count = 0;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d predictions outstanding",
                     cycle_count, due_results.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Phase control
    // ------------------------------------------------------------------
    task automatic write_object_type(input logic [1:0] v);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        obj_type_cfg = v;
        cfg_writes++;
    endtask

    // sender holds until every prediction is popped, then lets beats that
    // produce nothing work their way through before anything else happens
    task automatic wait_idle();
        @(negedge i_clk);
        while (beat_backlog.size() != 0 || push || due_results.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic stage_directed();
        // data beat with the walker idle: dropped
        stage_beat(CMD_DATA, 16'hFFFF, 32'hFFFF_FFFF);
        // empty message ends at once; the following beat hits the done state
        stage_beat(CMD_START, 16'd0, 32'h0000_0000);
        stage_beat(CMD_DATA, 16'h0000, 32'h0000_0000);
        // two bytes cannot hold a header
        stage_beat(CMD_START, 16'd2, 32'h0000_0000);
        // largest message, then a header claiming 3 bytes
        stage_beat(CMD_START, 16'hFFFF, 32'h0000_0000);
        stage_beat(CMD_DATA, 16'h0000, tlv_header(2'd3, 1'b1, 13'd3, 6'h3F, 10'h3FF));
        // longest header runs past a 16-byte message
        stage_beat(CMD_START, 16'd16, 32'hFFFF_FFFF);
        stage_beat(CMD_DATA, 16'hFFFF, tlv_header(2'd2, 1'b0, 13'h1FFF, 6'h15, 10'h2AA));
        // eight nested groups all closed by one bare leaf: largest fan-out
        stage_beat(CMD_START, 16'd36, 32'h0);
        for (int k = 0; k < 8; k++)
            stage_beat(CMD_DATA, 16'h0, tlv_header(k[0] ? 2'(k) : obj_type_cfg, k[0],
                       13'(36 - 4 * k), 6'(k * 9), 10'(k * 127)));
        stage_beat(CMD_DATA, 16'h0, tlv_header(obj_type_cfg + 2'd1, 1'b0, 13'd4, 6'h3F,
                                               10'h3FF));
        // a ninth group at full depth is refused
        stage_beat(CMD_START, 16'd40, 32'h0);
        for (int k = 0; k < 9; k++)
            stage_beat(CMD_DATA, 16'h0, tlv_header(k[0] ? 2'(k) : obj_type_cfg, k[0],
                       13'(40 - 4 * k), 6'(k * 7), 10'(k * 100)));
        commit_draft();
    endtask

    task automatic run_phase(input logic [1:0] obj, input bit long_hold);
        int unsigned staged;
        int unsigned sel;
        int unsigned k;
        write_object_type(obj);
        if (long_hold)
            hold_token <= hold_token + 1;
        staged = 0;
        while (staged < BEATS_PER_PHASE) begin
            sel = $urandom_range(0, 9);
            if (sel == 0) begin
                // noise: arbitrary length and raw words
                stage_beat(CMD_START, ($urandom_range(0, 1) != 0) ? 16'($urandom)
                                                                  : 16'($urandom_range(0, 64)),
                           $urandom);
                repeat ($urandom_range(1, 6))
                    stage_beat(CMD_DATA, 16'($urandom), $urandom);
            end else begin
                build_message(obj);
                if (sel == 1 && draft_beats.size() > 1) begin
                    // broken sequence: flip one bit in the upper half of a word
                    k = $urandom_range(1, draft_beats.size() - 1);
                    draft_beats[k].word = draft_beats[k].word ^ (32'd1 << $urandom_range(16, 31));
                end
            end
            staged += draft_beats.size();
            commit_draft();
        end
        wait_idle();
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_object_type(2'd0);
        stage_directed();
        wait_idle();

        run_phase(2'd3, 1'b0);
        run_phase(2'd1, 1'b1);   // receiver holds off while beats keep coming
        run_phase(2'd2, 1'b0);
        run_phase(2'($urandom_range(0, 3)), 1'b0);

        $display("walked %0d input beats across %0d object-type settings, %0d results checked",
                 beats_taken, cfg_writes, results_seen);
        $display("  %0d group ends, %0d message ends, %0d error beats, %0d mismatches",
                 group_ends, msg_ends, errors_seen, mismatch_count);
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/ntw_pkg.sv
rtl/ntw_front.sv
rtl/ntw_walker.sv
rtl/ntw_rq.sv
rtl/nested_tlv_stream_walker.sv
sim/tb_top.sv
